FILE: rtl/core/esdt_pkg.sv
// Shared types, constants and helpers for the event status decay tracker.
package esdt_pkg;

  // Channel store geometry
  localparam int unsigned CHANNELS = 32;
  localparam int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DecayW   = 16;
  localparam int unsigned MaskW    = 32;
  localparam int unsigned CatN     = 8;

  localparam logic [DecayW-1:0] DecayReset = DecayW'(5);

  typedef enum logic [1:0] {
    ModeEvent = 2'd0,
    ModeTick  = 2'd1,
    ModeQuery = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    KindMotion    = 4'd0,
    KindPixel     = 4'd1,
    KindHuman     = 4'd2,
    KindFace      = 4'd3,
    KindFaceRecog = 4'd4,
    KindVehicle   = 4'd5,
    KindAnimal    = 4'd6,
    KindPackage   = 4'd7,
    KindLineCross = 4'd8,
    KindIntrusion = 4'd9,
    KindDoorbell  = 4'd10
  } event_kind_e;

  typedef enum logic {
    RptChange = 1'b0,
    RptQuery  = 1'b1
  } rpt_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ChanW-1:0] channel;
    logic [3:0]       event_kind;
    logic [TimeW-1:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    rpt_kind_e        report_kind;
    logic [ChanW-1:0] channel_res;
    logic [CatN-1:0]  status_bits;
    logic             is_last;
    logic [MaskW-1:0] mask_motion;
    logic [MaskW-1:0] mask_human;
    logic [MaskW-1:0] mask_face;
    logic [MaskW-1:0] mask_vehicle;
    logic [MaskW-1:0] mask_animal;
    logic [MaskW-1:0] mask_package;
    logic [MaskW-1:0] mask_line_cross;
    logic [MaskW-1:0] mask_intrusion;
  } out_word_t;

  // One row per category, one bit per channel
  typedef logic [CatN-1:0][MaskW-1:0] mask_set_t;

  // Map an event kind to its status bit; zero for kinds without one
  function automatic logic [CatN-1:0] kind_bit(logic [3:0] kind);
    logic [CatN-1:0] b;
    b = '0;
    case (kind)
      KindMotion, KindPixel:    b = 8'h01;
      KindHuman:                b = 8'h02;
      KindFace, KindFaceRecog:  b = 8'h04;
      KindVehicle:              b = 8'h08;
      KindAnimal:               b = 8'h10;
      KindPackage:              b = 8'h20;
      KindLineCross:            b = 8'h40;
      KindIntrusion:            b = 8'h80;
      default:                  b = '0;
    endcase
    return b;
  endfunction

  // Gather one channel's status bits out of the category masks
  function automatic logic [CatN-1:0] chan_status(mask_set_t m, logic [ChanW-1:0] c);
    logic [CatN-1:0] s;
    for (int j = 0; j < CatN; j++) begin
      s[j] = m[j][c];
    end
    return s;
  endfunction

  // Build a result word
  function automatic out_word_t pack_word(rpt_kind_e kind, logic [ChanW-1:0] chan,
                                          logic [CatN-1:0] bits, logic last,
                                          mask_set_t m);
    out_word_t w;
    w.report_kind     = kind;
    w.channel_res     = chan;
    w.status_bits     = bits;
    w.is_last         = last;
    w.mask_motion     = m[0];
    w.mask_human      = m[1];
    w.mask_face       = m[2];
    w.mask_vehicle    = m[3];
    w.mask_animal     = m[4];
    w.mask_package    = m[5];
    w.mask_line_cross = m[6];
    w.mask_intrusion  = m[7];
    return w;
  endfunction

endpackage

FILE: rtl/core/event_status_decay_tracker_top.sv
// Per-channel detection status tracker with time-based decay of status bits.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_word_i  (in_word_t)
//   out     | output    | out_valid_o/out_ready_i| out_word_o (out_word_t)
//   cfg     | input     | cfg_we_i (no wait)     | cfg_wdata_i (decay seconds)
//
// An event of a kind with a status bit, or a query, loads one word into the output
// register. A tick scans the last-seen memory through its one read port, then steps
// through the channels in ascending order up to the last cleared one, each clear
// waiting for a free output register.
// Reset clears the status masks, the output valid and sets decay to 5; the
// last-seen memory is not cleared, as an entry only counts for a channel with
// status bits set, which an event has written.
// A stalled output holds its word; new words are taken only in idle.
module event_status_decay_tracker_top
  import esdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [DecayW-1:0] cfg_wdata_i
);

  state_e               state_q, state_d;
  mask_set_t            masks_q, masks_d;
  logic [CHANNELS-1:0]  clr_q, clr_d;
  logic [IdxW-1:0]      scan_q, scan_d;
  logic [IdxW-1:0]      emit_q, emit_d;
  logic [TimeW-1:0]     now_q, now_d;
  logic [DecayW-1:0]    decay_q;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  // Last-seen memory, one read and one write port
  logic [TimeW-1:0]     seen_mem [CHANNELS];
  logic [TimeW-1:0]     rd_data_q;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 mem_we;
  logic [IdxW-1:0]      wr_addr;

  logic                 in_fire;
  logic                 out_free;
  logic [CatN-1:0]      ev_bit;
  logic [CatN-1:0]      scan_stat;
  logic [TimeW-1:0]     age;
  logic                 scan_hit;
  logic [CHANNELS-1:0]  emit_rest;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ev_bit     = kind_bit(in_word_i.event_kind);

  // Scan check on the word read for scan_q
  assign scan_stat = chan_status(masks_q, ChanW'(scan_q));
  assign age       = now_q - rd_data_q;
  assign scan_hit  = (|scan_stat) && (age >= TimeW'(decay_q));

  // Pending clears above the one being emitted
  assign emit_rest = clr_q & ~(CHANNELS'(1) << emit_q);

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    masks_d     = masks_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    emit_d      = emit_q;
    now_d       = now_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    wr_addr     = in_word_i.channel[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (in_word_i.mode)
            ModeEvent: begin
              if ((ev_bit != '0) && ({1'b0, in_word_i.channel} < (ChanW + 1)'(CHANNELS))) begin
                mem_we = 1'b1;
                for (int j = 0; j < CatN; j++) begin
                  masks_d[j][in_word_i.channel] = masks_q[j][in_word_i.channel] | ev_bit[j];
                end
                out_d = pack_word(RptChange, in_word_i.channel,
                                  chan_status(masks_d, in_word_i.channel), 1'b1, masks_d);
                out_valid_d = 1'b1;
              end
            end
            ModeTick: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              scan_d  = '0;
              clr_d   = '0;
              now_d   = in_word_i.now_seconds;
              state_d = StScan;
            end
            ModeQuery: begin
              out_d       = pack_word(RptQuery, '0, '0, 1'b1, masks_q);
              out_valid_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      StScan: begin
        // Record the verdict for scan_q, fetch the next entry
        clr_d[scan_q] = scan_hit;
        if (scan_q == LastIdx) begin
          emit_d  = '0;
          state_d = (clr_d != '0) ? StEmit : StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + 1'b1;
          scan_d  = scan_q + 1'b1;
        end
      end

      StEmit: begin
        // Drop one channel per free output slot, in ascending order
        if (clr_q[emit_q]) begin
          if (out_free) begin
            for (int j = 0; j < CatN; j++) begin
              masks_d[j][emit_q] = 1'b0;
            end
            out_d = pack_word(RptChange, ChanW'(emit_q), '0, (emit_rest == '0), masks_d);
            out_valid_d = 1'b1;
            clr_d       = emit_rest;
            if (emit_rest == '0) begin
              state_d = StIdle;
            end else begin
              emit_d = emit_q + 1'b1;
            end
          end
        end else begin
          emit_d = emit_q + 1'b1;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      masks_q     <= '0;
      clr_q       <= '0;
      scan_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      decay_q     <= DecayReset;
    end else begin
      state_q     <= state_d;
      masks_q     <= masks_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        decay_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    out_q <= out_d;
  end

  // Last-seen memory: events write, the tick scan reads; never both at once
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem[wr_addr] <= in_word_i.now_seconds;
    end
    if (rd_en) begin
      rd_data_q <= seen_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // A change report's status matches that channel's column of its masks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.report_kind == RptChange) |->
      (out_word_o.status_bits == {out_word_o.mask_intrusion[out_word_o.channel_res],
                                  out_word_o.mask_line_cross[out_word_o.channel_res],
                                  out_word_o.mask_package[out_word_o.channel_res],
                                  out_word_o.mask_animal[out_word_o.channel_res],
                                  out_word_o.mask_vehicle[out_word_o.channel_res],
                                  out_word_o.mask_face[out_word_o.channel_res],
                                  out_word_o.mask_human[out_word_o.channel_res],
                                  out_word_o.mask_motion[out_word_o.channel_res]}))
    else $error("status bits disagree with masks");

  // Every channel pending a clear still has status bits set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |->
      ((clr_q != '0) &&
       ((clr_q & ~CHANNELS'(masks_q[0] | masks_q[1] | masks_q[2] | masks_q[3] |
                            masks_q[4] | masks_q[5] | masks_q[6] | masks_q[7])) == '0)))
    else $error("clear pending for an idle channel");

  // The scan never overlaps a write of the last-seen memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (!mem_we && $past(state_q) != StEmit))
    else $error("memory write during scan");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the event status decay tracker top level.
module tb_top
  import esdt_pkg::*;
();

  localparam int          MaxGap       = 12;
  localparam int          HoldCycles   = 300;
  localparam int          HoldAfter    = 60;
  localparam int          IdleGap      = 2 * CHANNELS + 16;
  localparam int          StallLimit   = 3000;
  localparam int          PhaseItems   = 40;
  localparam int          MaxReported  = 10;
  localparam logic [1:0]  ModeUnused   = 2'd3;
  localparam logic [3:0]  KindUnknownHi = 4'd15;

  typedef struct {
    in_word_t  word;
    bit        typed;
    int        typed_n;
    out_word_t exp;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_word   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              cfg_we    = 1'b0;
  logic [DecayW-1:0] cfg_wdata = '0;

  // Channel status mirror
  logic [CatN-1:0]   chan_status [CHANNELS];
  logic [TimeW-1:0]  chan_seen [CHANNELS];
  logic [DecayW-1:0] decay_cfg;

  out_word_t pending_reports[$];
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        reports_seen = 0;
  int        idle_cycles = 0;
  bit        tx_burst = 1'b0;

  event_status_decay_tracker_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Map an event kind to its category bit
  function automatic logic [CatN-1:0] category_of(logic [3:0] kind);
    case (kind)
      KindMotion, KindPixel:   return 8'h01;
      KindHuman:               return 8'h02;
      KindFace, KindFaceRecog: return 8'h04;
      KindVehicle:             return 8'h08;
      KindAnimal:              return 8'h10;
      KindPackage:             return 8'h20;
      KindLineCross:           return 8'h40;
      KindIntrusion:           return 8'h80;
      default:                 return '0;
    endcase
  endfunction

  // Build a report word with masks gathered from the current status mirror
  function automatic out_word_t status_report(rpt_kind_e kind, logic [ChanW-1:0] chan,
                                              logic [CatN-1:0] bits, logic last);
    out_word_t       w;
    logic [MaskW-1:0] m [CatN];
    for (int j = 0; j < CatN; j++) m[j] = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int j = 0; j < CatN; j++) begin
        if (chan_status[c][j]) m[j][c] = 1'b1;
      end
    end
    w.report_kind     = kind;
    w.channel_res     = chan;
    w.status_bits     = bits;
    w.is_last         = last;
    w.mask_motion     = m[0];
    w.mask_human      = m[1];
    w.mask_face       = m[2];
    w.mask_vehicle    = m[3];
    w.mask_animal     = m[4];
    w.mask_package    = m[5];
    w.mask_line_cross = m[6];
    w.mask_intrusion  = m[7];
    return w;
  endfunction

  // Advance the status mirror by one input word and append the reports it causes
  function automatic void predict_status(input in_word_t w, ref out_word_t res[$]);
    logic [CatN-1:0]  cat;
    logic [TimeW-1:0] age;
    int               n;
    n = 0;
    case (w.mode)
      ModeEvent: begin
        cat = category_of(w.event_kind);
        if (cat != '0 && w.channel < CHANNELS) begin
          chan_status[w.channel] = chan_status[w.channel] | cat;
          chan_seen[w.channel]   = w.now_seconds;
          res.push_back(status_report(RptChange, w.channel, chan_status[w.channel], 1'b1));
        end
      end
      ModeTick: begin
        for (int c = 0; c < CHANNELS; c++) begin
          age = w.now_seconds - chan_seen[c];
          if (chan_status[c] != '0 && age >= TimeW'(decay_cfg)) begin
            chan_status[c] = '0;
            res.push_back(status_report(RptChange, ChanW'(c), '0, 1'b0));
            n++;
          end
        end
        if (n > 0) res[res.size() - 1].is_last = 1'b1;
      end
      ModeQuery: res.push_back(status_report(RptQuery, '0, '0, 1'b1));
      default: ;
    endcase
  endfunction

  // Typed expectation for directed rows: only motion and intrusion masks in use
  function automatic out_word_t typed_report(rpt_kind_e kind, logic [ChanW-1:0] chan,
                                             logic [CatN-1:0] bits, logic [MaskW-1:0] motion,
                                             logic [MaskW-1:0] intrusion);
    out_word_t w;
    w                = '0;
    w.report_kind    = kind;
    w.channel_res    = chan;
    w.status_bits    = bits;
    w.is_last        = 1'b1;
    w.mask_motion    = motion;
    w.mask_intrusion = intrusion;
    return w;
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [ChanW-1:0] chan, logic [3:0] kind,
                                  logic [TimeW-1:0] now, bit typed, int typed_n,
                                  out_word_t exp);
    dir_row_t r;
    r.word.mode        = mode;
    r.word.channel     = chan;
    r.word.event_kind  = kind;
    r.word.now_seconds = now;
    r.typed            = typed;
    r.typed_n          = typed_n;
    r.exp              = exp;
    dir_rows.push_back(r);
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input in_word_t w);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for all reports, then let a trailing tick scan finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (IdleGap) @(posedge clk);
  endtask

  task automatic set_decay(input logic [DecayW-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    decay_cfg = v;
  endtask

  function automatic void check_field(string name, logic [MaskW-1:0] e, logic [MaskW-1:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("mismatch %s: expected %h, got %h", name, e, a);
    end
  endfunction

  // Sink: random stalls, one long hold-off, compare each word against the oldest report
  initial begin
    int        stall;
    bit        rx_burst;
    bit        held_off;
    out_word_t e;
    rx_burst = 1'b0;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MaxGap);
      if (!held_off && reports_seen >= HoldAfter) begin
        stall    = HoldCycles;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected word: %h", out_word);
      end else begin
        e = pending_reports.pop_front();
        check_field("report_kind", e.report_kind, out_word.report_kind);
        check_field("channel_res", e.channel_res, out_word.channel_res);
        check_field("status_bits", e.status_bits, out_word.status_bits);
        check_field("is_last", e.is_last, out_word.is_last);
        check_field("mask_motion", e.mask_motion, out_word.mask_motion);
        check_field("mask_human", e.mask_human, out_word.mask_human);
        check_field("mask_face", e.mask_face, out_word.mask_face);
        check_field("mask_vehicle", e.mask_vehicle, out_word.mask_vehicle);
        check_field("mask_animal", e.mask_animal, out_word.mask_animal);
        check_field("mask_package", e.mask_package, out_word.mask_package);
        check_field("mask_line_cross", e.mask_line_cross, out_word.mask_line_cross);
        check_field("mask_intrusion", e.mask_intrusion, out_word.mask_intrusion);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    out_word_t        scratch[$];
    out_word_t        none;
    in_word_t         w;
    logic [TimeW-1:0] clock_s;
    logic [DecayW-1:0] decays [5];
    int               done_items;
    int               pick;
    bit               noise;

    none = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      chan_status[c] = '0;
      chan_seen[c]   = '0;
    end
    decay_cfg = DecayReset;

    // Directed rows, decay at its reset value
    add_row(ModeQuery, 5'd0, KindMotion, 32'd0, 1'b1, 1,
            typed_report(RptQuery, 5'd0, 8'h00, 32'h0, 32'h0));
    add_row(ModeTick, 5'd0, KindMotion, 32'd100, 1'b1, 0, none);
    add_row(ModeEvent, 5'd0, KindMotion, 32'd10, 1'b1, 1,
            typed_report(RptChange, 5'd0, 8'h01, 32'h1, 32'h0));
    add_row(ModeEvent, 5'd31, KindIntrusion, 32'd10, 1'b1, 1,
            typed_report(RptChange, 5'd31, 8'h80, 32'h1, 32'h8000_0000));
    add_row(ModeEvent, 5'd31, KindDoorbell, 32'd11, 1'b1, 0, none);
    add_row(ModeEvent, 5'd5, KindUnknownHi, 32'd11, 1'b1, 0, none);
    add_row(ModeUnused, 5'd31, KindUnknownHi, 32'hFFFF_FFFF, 1'b1, 0, none);
    add_row(ModeEvent, 5'd1, KindPixel, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd2, KindHuman, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd3, KindFace, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd4, KindFaceRecog, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd5, KindVehicle, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd6, KindAnimal, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd7, KindPackage, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd8, KindLineCross, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd9, KindIntrusion, 32'd12, 1'b0, 0, none);
    add_row(ModeEvent, 5'd0, KindHuman, 32'd12, 1'b0, 0, none);
    add_row(ModeQuery, 5'd17, KindDoorbell, 32'd12, 1'b0, 0, none);
    add_row(ModeTick, 5'd0, KindMotion, 32'd14, 1'b0, 0, none);
    add_row(ModeTick, 5'd0, KindMotion, 32'd15, 1'b0, 0, none);
    add_row(ModeTick, 5'd0, KindMotion, 32'd17, 1'b0, 0, none);
    // Age wraps around the top of the time range
    add_row(ModeEvent, 5'd20, KindMotion, 32'hFFFF_FFFE, 1'b0, 0, none);
    add_row(ModeEvent, 5'd10, KindHuman, 32'hFFFF_FFFF, 1'b0, 0, none);
    add_row(ModeTick, 5'd0, KindMotion, 32'd3, 1'b0, 0, none);
    add_row(ModeTick, 5'd0, KindMotion, 32'd4, 1'b0, 0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word);
      if (dir_rows[i].typed) begin
        scratch.delete();
        predict_status(dir_rows[i].word, scratch);
        if (dir_rows[i].typed_n > 0) pending_reports.push_back(dir_rows[i].exp);
      end else begin
        predict_status(dir_rows[i].word, pending_reports);
      end
    end

    // Random phases over several decay settings, the extremes and zero
    decays[0] = 16'd1;
    decays[1] = 16'hFFFF;
    decays[2] = 16'd0;
    decays[3] = DecayW'($urandom_range(2, 30));
    decays[4] = 16'd7;
    clock_s   = $urandom_range(0, 1000);
    foreach (decays[p]) begin
      set_decay(decays[p]);
      done_items = 0;
      while (done_items < PhaseItems) begin
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        // Advance time: mostly small steps, sometimes a decay-sized jump or a wild value
        pick = $urandom_range(0, 99);
        if (pick < 6) clock_s = $urandom();
        else if (pick < 14) clock_s = clock_s + $urandom_range(0, 70000);
        else clock_s = clock_s + $urandom_range(0, 3);
        w.channel     = ChanW'($urandom_range(0, CHANNELS - 1));
        w.now_seconds = clock_s;
        noise         = 1'b0;
        pick          = $urandom_range(0, 99);
        if (pick < 55) begin
          w.mode       = ModeEvent;
          w.event_kind = 4'($urandom_range(KindMotion, KindIntrusion));
        end else if (pick < 75) begin
          w.mode       = ModeTick;
          w.event_kind = 4'($urandom_range(0, KindUnknownHi));
        end else if (pick < 88) begin
          w.mode       = ModeQuery;
          w.event_kind = 4'($urandom_range(0, KindUnknownHi));
        end else if (pick < 94) begin
          w.mode       = ModeEvent;
          w.event_kind = 4'($urandom_range(KindDoorbell, KindUnknownHi));
          noise        = 1'b1;
        end else begin
          w.mode       = ModeUnused;
          w.event_kind = 4'($urandom_range(0, KindUnknownHi));
          noise        = 1'b1;
        end
        send_word(w);
        predict_status(w, pending_reports);
        if (!noise) done_items++;
      end
    end

    settle();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: event_status_decay_tracker_top.f
rtl/core/esdt_pkg.sv
rtl/core/event_status_decay_tracker_top.sv
test/tb_top.sv
